@@ hw/rtl/sdi_pkg.sv @@
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants for the SD card SPI-mode start-up sequencer.
// ----------------------------------------------------------------------------
package sdi_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 1'd1;

  localparam logic [7:0] POLL_LIMIT_RST = 8'd16;
  localparam logic [15:0] RETRY_LIMIT_RST = 16'd1024;

  // input beat command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_XFER_DONE = 1'b1;

  // transfer kinds
  localparam logic KIND_INIT = 1'b0;
  localparam logic KIND_DIRECT = 1'b1;

  // run status codes
  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_HIGH_CAP = 3'd1,
    ST_CMD0_ERR = 3'd2,
    ST_ACMD41_ERR = 3'd3,
    ST_CMD58_ERR = 3'd4
  } status_e;

  // byte constants
  localparam logic [7:0] BYTE_IDLE = 8'hFF;
  localparam logic [7:0] CMD_START_BITS = 8'h40;
  localparam logic [7:0] R1_IDLE = 8'h01;
  localparam logic [7:0] R1_ILLEGAL_CMD = 8'h05;
  localparam logic [7:0] R1_READY = 8'h00;
  localparam logic [7:0] CRC_CMD0 = 8'h95;
  localparam logic [7:0] CRC_CMD8 = 8'h87;
  localparam logic [7:0] CRC_DUMMY = 8'h01;
  localparam logic [7:0] CHECK_PATTERN = 8'hAA;
  localparam logic [7:0] VHS_27_36 = 8'h01;
  localparam logic [7:0] HCS_ARG = 8'h40;

  // one result beat
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       transfer_kind;
    logic       transfer_valid;
    logic       done_res;
    status_e    status;
  } sdi_res_t;

endpackage

@@ hw/rtl/sdi_core.sv @@
// ----------------------------------------------------------------------------
// sdi_core
// Sequencer state and next-byte decision for one registered input beat.
// ----------------------------------------------------------------------------
module sdi_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              command_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        poll_limit_i,
  input  logic [15:0]       retry_limit_i,
  output sdi_pkg::sdi_res_t res_o
);
  import sdi_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD0,
    PH_CMD8,
    PH_R7,
    PH_CMD55,
    PH_ACMD41,
    PH_CMD1,
    PH_CMD58,
    PH_R3,
    PH_DESEL_A41,
    PH_DESEL_END
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_FRAME,
    ACT_READS,
    ACT_FINISH
  } act_e;

  localparam logic [3:0] IDX_CRC = 4'd6;
  localparam logic [3:0] IDX_POLL = 4'd7;
  localparam logic [3:0] IDX_LAST_READ = 4'd3;

  function automatic logic [7:0] cmd_index(phase_e ph);
    logic [7:0] idx;
    unique case (ph)
      PH_CMD8:   idx = 8'd8;
      PH_CMD55:  idx = 8'd55;
      PH_ACMD41: idx = 8'd41;
      PH_CMD1:   idx = 8'd1;
      PH_CMD58:  idx = 8'd58;
      default:   idx = 8'd0;
    endcase
    return idx;
  endfunction

  // byte of the command frame at position idx (1 = command, 2..5 = argument, 6 = CRC)
  function automatic logic [7:0] frame_byte(phase_e ph, logic [3:0] idx);
    logic [7:0] b;
    b = BYTE_IDLE;
    if (idx == 4'd1) begin
      b = CMD_START_BITS | cmd_index(ph);
    end else if (idx >= 4'd2 && idx <= 4'd5) begin
      b = 8'h00;
      if (ph == PH_CMD8) begin
        if (idx == 4'd4) b = VHS_27_36;
        else if (idx == 4'd5) b = CHECK_PATTERN;
      end else if (ph == PH_ACMD41 || ph == PH_CMD1) begin
        if (idx == 4'd2) b = HCS_ARG;
      end
    end else if (idx == IDX_CRC) begin
      if (ph == PH_CMD0) b = CRC_CMD0;
      else if (ph == PH_CMD8) b = CRC_CMD8;
      else b = CRC_DUMMY;
    end
    return b;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  poll_q, poll_d;
  logic [15:0] retry_q, retry_d;
  logic [7:0]  last_q, last_d;
  logic        hcs_q, hcs_d;

  act_e        act;
  phase_e      act_phase;
  logic [7:0]  emit_byte;
  logic        emit_kind;
  status_e     act_status;
  logic        do_resp;
  logic [7:0]  resp;
  logic [15:0] retry_inc;

  always_comb begin
    retry_d    = retry_q;
    hcs_d      = hcs_q;
    last_d     = last_q;
    idx_d      = idx_q;
    poll_d     = poll_q;
    act        = ACT_NONE;
    act_phase  = PH_IDLE;
    emit_byte  = BYTE_IDLE;
    emit_kind  = KIND_INIT;
    act_status = ST_OK;
    do_resp    = 1'b0;
    resp       = BYTE_IDLE;
    retry_inc  = retry_q + 16'd1;

    if (command_i == CMD_START) begin
      retry_d   = '0;
      hcs_d     = 1'b0;
      last_d    = BYTE_IDLE;
      act       = ACT_FRAME;
      act_phase = PH_CMD0;
    end else begin
      unique case (phase_q)
        PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_CMD1, PH_CMD58: begin
          if (idx_q < IDX_CRC) begin
            idx_d     = idx_q + 4'd1;
            act       = ACT_EMIT;
            emit_byte = frame_byte(phase_q, idx_q + 4'd1);
          end else if (idx_q == IDX_CRC) begin
            idx_d = IDX_POLL;
            if (poll_limit_i == 8'd0) begin
              do_resp = 1'b1;
            end else begin
              poll_d = 8'd1;
              act    = ACT_EMIT;
            end
          end else if (rx_byte_i != BYTE_IDLE) begin
            do_resp = 1'b1;
            resp    = rx_byte_i;
          end else if (poll_q < poll_limit_i) begin
            poll_d = poll_q + 8'd1;
            act    = ACT_EMIT;
          end else begin
            do_resp = 1'b1;
          end
        end
        PH_R7: begin
          if (idx_q < IDX_LAST_READ) begin
            idx_d     = idx_q + 4'd1;
            act       = ACT_EMIT;
            emit_kind = KIND_DIRECT;
          end else begin
            retry_d = '0;
            if (retry_limit_i == 16'd0) begin
              act       = ACT_READS;
              act_phase = PH_DESEL_A41;
            end else begin
              act       = ACT_FRAME;
              act_phase = PH_CMD55;
            end
          end
        end
        PH_R3: begin
          if (idx_q == 4'd0 && rx_byte_i[6]) hcs_d = 1'b1;
          if (idx_q < IDX_LAST_READ) begin
            idx_d     = idx_q + 4'd1;
            act       = ACT_EMIT;
            emit_kind = KIND_DIRECT;
          end else begin
            act       = ACT_READS;
            act_phase = PH_DESEL_END;
          end
        end
        PH_DESEL_A41: begin
          act        = ACT_FINISH;
          act_status = ST_ACMD41_ERR;
        end
        PH_DESEL_END: begin
          act = ACT_FINISH;
          if (last_q != R1_READY) act_status = ST_CMD58_ERR;
          else if (hcs_q) act_status = ST_HIGH_CAP;
          else act_status = ST_OK;
        end
        default: begin
          act       = ACT_READS;
          act_phase = PH_IDLE;
        end
      endcase

      if (do_resp) begin
        last_d = resp;
        unique case (phase_q)
          PH_CMD0: begin
            if (resp != R1_IDLE) begin
              act        = ACT_FINISH;
              act_status = ST_CMD0_ERR;
            end else begin
              act       = ACT_FRAME;
              act_phase = PH_CMD8;
            end
          end
          PH_CMD8: begin
            act       = ACT_READS;
            act_phase = PH_R7;
          end
          PH_CMD55: begin
            act       = ACT_FRAME;
            act_phase = PH_ACMD41;
          end
          PH_ACMD41: begin
            retry_d = retry_inc;
            act     = ACT_FRAME;
            if (resp == R1_IDLE && retry_inc < retry_limit_i) begin
              act_phase = PH_CMD55;
            end else if (resp == R1_ILLEGAL_CMD) begin
              act_phase = PH_CMD1;
            end else if (resp[0]) begin
              act       = ACT_READS;
              act_phase = PH_DESEL_A41;
            end else begin
              act_phase = PH_CMD58;
            end
          end
          PH_CMD1: begin
            if (resp[0]) begin
              act       = ACT_READS;
              act_phase = PH_DESEL_A41;
            end else begin
              act       = ACT_FRAME;
              act_phase = PH_CMD58;
            end
          end
          default: begin
            act       = ACT_READS;
            act_phase = PH_R3;
          end
        endcase
      end
    end

    // apply the chosen action
    phase_d = phase_q;
    res_o   = '{tx_byte: BYTE_IDLE, transfer_kind: KIND_INIT, transfer_valid: 1'b0,
                done_res: 1'b0, status: ST_OK};
    unique case (act)
      ACT_EMIT: begin
        res_o.tx_byte        = emit_byte;
        res_o.transfer_kind  = emit_kind;
        res_o.transfer_valid = 1'b1;
      end
      ACT_FRAME: begin
        phase_d              = act_phase;
        idx_d                = '0;
        poll_d               = '0;
        res_o.transfer_valid = 1'b1;
      end
      ACT_READS: begin
        // read and deselect starts; also the idle fallback, which sends nothing
        phase_d = act_phase;
        if (act_phase != PH_IDLE) begin
          idx_d                = '0;
          res_o.transfer_kind  = KIND_DIRECT;
          res_o.transfer_valid = 1'b1;
        end
      end
      ACT_FINISH: begin
        phase_d        = PH_IDLE;
        idx_d          = '0;
        poll_d         = '0;
        res_o.done_res = 1'b1;
        res_o.status   = act_status;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      poll_q  <= '0;
      retry_q <= '0;
      last_q  <= BYTE_IDLE;
      hcs_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      poll_q  <= poll_d;
      retry_q <= retry_d;
      last_q  <= last_d;
      hcs_q   <= hcs_d;
    end
  end

endmodule

@@ hw/rtl/sd_spi_init_sequencer.sv @@
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer
// SD card SPI-mode start-up sequencer: one byte decision per input beat.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// cfg     | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
// in      | in        | in_valid_i / in_ready_o | command_i, rx_byte_i
// out     | out       | out_valid_o / out_ready_i | tx_byte_o, transfer_kind_o,
//         |           |                        | transfer_valid_o, done_res_o, status_o
//
// an accepted beat lands in the input register and is decided from there into
// the output register once that register is free or draining; one beat per cycle
// sustained while the output is not stalled; the sequencer state update is the only loop
// reset returns both limits to their defaults and the sequencer to idle
// a stalled output holds the input register; in_ready_o stays high while it can drain
module sd_spi_init_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sdi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdi_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   tx_byte_o,
  output logic                         transfer_kind_o,
  output logic                         transfer_valid_o,
  output logic                         done_res_o,
  output logic [2:0]                   status_o
);
  import sdi_pkg::*;

  logic [7:0]  poll_limit_q;
  logic [15:0] retry_limit_q;

  logic        in_valid_q;
  logic        cmd_q;
  logic [7:0]  rx_q;
  logic        out_valid_q;
  sdi_res_t    res_q;
  sdi_res_t    res;
  logic        step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q  <= POLL_LIMIT_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLL_LIMIT:  poll_limit_q <= cfg_wdata_i[7:0];
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // decide the held beat when the output register is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      rx_q  <= rx_byte_i;
    end
  end

  sdi_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .command_i     (cmd_q),
    .rx_byte_i     (rx_q),
    .poll_limit_i  (poll_limit_q),
    .retry_limit_i (retry_limit_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tx_byte_o        = res_q.tx_byte;
  assign transfer_kind_o  = res_q.transfer_kind;
  assign transfer_valid_o = res_q.transfer_valid;
  assign done_res_o       = res_q.done_res;
  assign status_o         = res_q.status;

endmodule
